// ===== rtl/joystick_deadzone_drive_mixer_core_macros.svh =====
// Assertion helpers for the drive mixer core.
`ifndef JOYSTICK_DEADZONE_DRIVE_MIXER_CORE_MACROS_SVH
`define JOYSTICK_DEADZONE_DRIVE_MIXER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define JDDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("drive mixer check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define JDDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("drive mixer check failed");

`endif

// ===== rtl/jddm_pkg.sv =====
package jddm_pkg;

    localparam int SPEED_LIMIT     = 127;
    localparam int TURN_FROM_TWIST = 1;

    localparam int POS_W     = 10;
    localparam int LIM_W     = $clog2(SPEED_LIMIT + 1);
    localparam int NUM_W     = LIM_W + POS_W;
    localparam int WRAP_W    = 16;
    localparam int Q_EXT_W   = (NUM_W > WRAP_W) ? NUM_W : WRAP_W;
    localparam int SPEED_W   = 15;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;

    localparam logic signed [WRAP_W-1:0]  LIM16 = WRAP_W'(SPEED_LIMIT);
    localparam logic signed [SPEED_W-1:0] LIM15 = SPEED_W'(SPEED_LIMIT);
    localparam logic signed [WRAP_W+1:0]  LIM18 = (WRAP_W+2)'(SPEED_LIMIT);

    localparam logic [CFG_IDX_W-1:0] REG_FWD_EDGE_A  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FWD_DEAD_A  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FWD_DEAD_B  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FWD_EDGE_B  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_EDGE_A = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DEAD_A = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DEAD_B = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_EDGE_B = CFG_IDX_W'(7);

    localparam logic [STATE_W-1:0] STEER_STRAIGHT = 2'd0;
    localparam logic [STATE_W-1:0] STEER_LEFT     = 2'd1;
    localparam logic [STATE_W-1:0] STEER_RIGHT    = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [POS_W-1:0] den;
    } axis_job_t;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] quo;
    } axis_quo_t;

    typedef struct packed {
        logic [STATE_W-1:0] turn_state;
        logic [SPEED_W-1:0] right_speed;
        logic [SPEED_W-1:0] left_speed;
    } mix_result_t;

endpackage

// ===== rtl/jddm_axis_front.sv =====
module jddm_axis_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [jddm_pkg::POS_W-1:0]  pos,
    input  logic [jddm_pkg::POS_W-1:0]  edge_a,
    input  logic [jddm_pkg::POS_W-1:0]  dead_a,
    input  logic [jddm_pkg::POS_W-1:0]  dead_b,
    input  logic [jddm_pkg::POS_W-1:0]  edge_b,
    output logic                        out_valid,
    output jddm_pkg::axis_job_t         job
);
    import jddm_pkg::*;

    logic             up;
    logic             side_a;
    logic             side_b;
    logic [POS_W-1:0] z;
    logic [POS_W-1:0] e;
    logic             pos_lo;
    logic             den_neg;
    logic [POS_W-1:0] diff_mag;
    logic [POS_W-1:0] den_mag;
    logic             active;

    logic             s1_valid_reg;
    logic             s1_neg_reg;
    logic [POS_W-1:0] s1_diff_reg;
    logic [POS_W-1:0] s1_den_reg;
    logic             s2_valid_reg;
    axis_job_t        s2_job_reg;
    axis_job_t        s2_job_next;

    always_comb begin
        up       = edge_b > edge_a;
        side_a   = up ? (pos < dead_a) : (pos > dead_a);
        side_b   = up ? (pos > dead_b) : (pos < dead_b);
        z        = side_a ? dead_a : dead_b;
        e        = side_a ? edge_a : edge_b;
        pos_lo   = pos < z;
        diff_mag = pos_lo ? (z - pos) : (pos - z);
        den_neg  = e < z;
        den_mag  = den_neg ? (z - e) : (e - z);
        active   = (side_a | side_b) && (e != z);
    end

    always_comb begin
        s2_job_next.neg = s1_neg_reg;
        s2_job_next.num = NUM_W'(s1_diff_reg) * NUM_W'(SPEED_LIMIT);
        s2_job_next.den = s1_den_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_neg_reg  <= (side_a ? ~pos_lo : pos_lo) ^ den_neg;
            s1_diff_reg <= active ? diff_mag : '0;
            s1_den_reg  <= active ? den_mag : POS_W'(1);
            s2_job_reg  <= s2_job_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign job       = s2_job_reg;

endmodule

// ===== rtl/jddm_div.sv =====
module jddm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  jddm_pkg::axis_job_t job,
    output logic                out_valid,
    output jddm_pkg::axis_quo_t res
);
    import jddm_pkg::*;

    logic [NUM_W-1:0] valid_reg;
    logic [POS_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [POS_W-1:0] den_reg [NUM_W];
    logic             neg_reg [NUM_W];

    logic [POS_W-1:0] rem_in  [NUM_W];
    logic [NUM_W-1:0] nq_in   [NUM_W];
    logic [POS_W-1:0] den_in  [NUM_W];
    logic             neg_in  [NUM_W];
    logic [POS_W:0]   trial   [NUM_W];
    logic             ge      [NUM_W];
    logic [POS_W:0]   diff    [NUM_W];
    logic [POS_W-1:0] rem_next[NUM_W];
    logic [NUM_W-1:0] nq_next [NUM_W];

    always_comb begin
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                rem_in[s] = '0;
                nq_in[s]  = job.num;
                den_in[s] = job.den;
                neg_in[s] = job.neg;
            end else begin
                rem_in[s] = rem_reg[s-1];
                nq_in[s]  = nq_reg[s-1];
                den_in[s] = den_reg[s-1];
                neg_in[s] = neg_reg[s-1];
            end
            trial[s]    = {rem_in[s], nq_in[s][NUM_W-1]};
            diff[s]     = trial[s] - {1'b0, den_in[s]};
            ge[s]       = trial[s] >= {1'b0, den_in[s]};
            rem_next[s] = ge[s] ? diff[s][POS_W-1:0] : trial[s][POS_W-1:0];
            nq_next[s]  = {nq_in[s][NUM_W-2:0], ge[s]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < NUM_W; s++) begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
                den_reg[s] <= den_in[s];
                neg_reg[s] <= neg_in[s];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign res.neg   = neg_reg[NUM_W-1];
    assign res.quo   = nq_reg[NUM_W-1];

endmodule

// ===== rtl/jddm_mix.sv =====
module jddm_mix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  jddm_pkg::axis_quo_t   fwd_quo,
    input  jddm_pkg::axis_quo_t   turn_quo,
    output logic                  out_valid,
    output jddm_pkg::mix_result_t result
);
    import jddm_pkg::*;

    logic        [Q_EXT_W-1:0]  fwd_ext;
    logic        [Q_EXT_W-1:0]  turn_ext;
    logic signed [WRAP_W-1:0]   fwd_w;
    logic signed [WRAP_W-1:0]   turn_w;
    logic signed [WRAP_W-1:0]   fwd_c;
    logic signed [WRAP_W-1:0]   turn_c;
    logic signed [WRAP_W:0]     turn_adj;
    logic signed [WRAP_W:0]     half_full;
    logic        [STATE_W-1:0]  state_next;

    logic                       p1_valid_reg;
    logic signed [WRAP_W-1:0]   p1_fwd_reg;
    logic signed [WRAP_W-1:0]   p1_half_reg;
    logic        [STATE_W-1:0]  p1_state_reg;

    logic signed [WRAP_W+1:0]   left_sum;
    logic signed [WRAP_W+1:0]   right_sum;
    logic signed [WRAP_W+1:0]   left_c;
    logic signed [WRAP_W+1:0]   right_c;

    logic                       p2_valid_reg;
    mix_result_t                p2_res_reg;
    mix_result_t                p2_res_next;

    always_comb begin
        fwd_ext  = Q_EXT_W'(fwd_quo.quo);
        turn_ext = Q_EXT_W'(turn_quo.quo);
        fwd_w    = fwd_quo.neg  ? -fwd_ext[WRAP_W-1:0]  : fwd_ext[WRAP_W-1:0];
        turn_w   = turn_quo.neg ? -turn_ext[WRAP_W-1:0] : turn_ext[WRAP_W-1:0];
        fwd_c    = (fwd_w > LIM16)  ? LIM16 : fwd_w;
        turn_c   = (turn_w > LIM16) ? LIM16 : turn_w;
        turn_adj = {turn_c[WRAP_W-1], turn_c} + (WRAP_W+1)'(turn_c[WRAP_W-1]);
        half_full = turn_adj >>> 1;
        if (turn_c[WRAP_W-1]) begin
            state_next = STEER_LEFT;
        end else if (turn_c != '0) begin
            state_next = STEER_RIGHT;
        end else begin
            state_next = STEER_STRAIGHT;
        end
    end

    always_comb begin
        left_sum  = (WRAP_W+2)'(p1_fwd_reg) - (WRAP_W+2)'(p1_half_reg);
        right_sum = (WRAP_W+2)'(p1_fwd_reg) + (WRAP_W+2)'(p1_half_reg);
        left_c    = (left_sum > LIM18)   ? LIM18  :
                    (left_sum < -LIM18)  ? -LIM18 : left_sum;
        right_c   = (right_sum > LIM18)  ? LIM18  :
                    (right_sum < -LIM18) ? -LIM18 : right_sum;
        p2_res_next.left_speed  = left_c[SPEED_W-1:0];
        p2_res_next.right_speed = right_c[SPEED_W-1:0];
        p2_res_next.turn_state  = p1_state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_fwd_reg   <= fwd_c;
            p1_half_reg  <= half_full[WRAP_W-1:0];
            p1_state_reg <= state_next;
            p2_res_reg   <= p2_res_next;
        end
    end

    assign out_valid = p2_valid_reg;
    assign result    = p2_res_reg;

endmodule

// ===== rtl/joystick_deadzone_drive_mixer_core.sv =====
// Joystick dead-zone differential drive mixer.
// s_ channel: one 4-byte joystick report per request, byte 0 in s_tdata[7:0].
// m_ channel: left and right wheel commands and the turn status per report.
// cfg_ channel: writes one of eight 10-bit dead-zone registers (index 0..7);
// other indexes are dropped. cfg_ready is always high. Write registers only
// while no report is in flight.
// Path from s_ accept to m_tvalid: the axis front registers, the divider stages
// and the mixer registers; the restoring divider takes one quotient bit per stage.
// Throughput: one report per cycle while m_tready is high.
// When the receiver stalls, the whole pipeline holds and s_tready drops; the
// pending result stays on m_tdata until taken.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// default dead-zone registers.
`include "joystick_deadzone_drive_mixer_core_macros.svh"

module joystick_deadzone_drive_mixer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // report_byte0, report_byte1, report_byte2, report_byte3
    input  logic [31:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // left_speed, right_speed, turn_state
    output logic [31:0]                     m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jddm_pkg::POS_W-1:0]      cfg_data
);
    import jddm_pkg::*;

    logic [POS_W-1:0] fwd_edge_a_reg;
    logic [POS_W-1:0] fwd_dead_a_reg;
    logic [POS_W-1:0] fwd_dead_b_reg;
    logic [POS_W-1:0] fwd_edge_b_reg;
    logic [POS_W-1:0] turn_edge_a_reg;
    logic [POS_W-1:0] turn_dead_a_reg;
    logic [POS_W-1:0] turn_dead_b_reg;
    logic [POS_W-1:0] turn_edge_b_reg;

    logic             adv;
    logic             accept;
    logic [POS_W-1:0] axis_x;
    logic [POS_W-1:0] axis_y;
    logic [POS_W-1:0] axis_twist;
    logic [POS_W-1:0] turn_pos;

    logic             fwd_front_valid;
    logic             turn_front_valid;
    axis_job_t        fwd_job;
    axis_job_t        turn_job;
    logic             fwd_div_valid;
    logic             turn_div_valid;
    axis_quo_t        fwd_quo;
    axis_quo_t        turn_quo;
    logic             mix_valid;
    mix_result_t      mix_res;

    assign adv       = !mix_valid || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    assign axis_x     = {s_tdata[9:8], s_tdata[7:0]};
    assign axis_y     = {s_tdata[19:16], s_tdata[15:10]};
    assign axis_twist = {2'b00, s_tdata[31:24]};
    assign turn_pos   = (TURN_FROM_TWIST != 0) ? axis_twist : axis_x;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_edge_a_reg  <= POS_W'(1023);
            fwd_dead_a_reg  <= POS_W'(540);
            fwd_dead_b_reg  <= POS_W'(480);
            fwd_edge_b_reg  <= POS_W'(0);
            turn_edge_a_reg <= POS_W'(0);
            turn_dead_a_reg <= POS_W'(118);
            turn_dead_b_reg <= POS_W'(138);
            turn_edge_b_reg <= POS_W'(255);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FWD_EDGE_A:  fwd_edge_a_reg  <= cfg_data;
                REG_FWD_DEAD_A:  fwd_dead_a_reg  <= cfg_data;
                REG_FWD_DEAD_B:  fwd_dead_b_reg  <= cfg_data;
                REG_FWD_EDGE_B:  fwd_edge_b_reg  <= cfg_data;
                REG_TURN_EDGE_A: turn_edge_a_reg <= cfg_data;
                REG_TURN_DEAD_A: turn_dead_a_reg <= cfg_data;
                REG_TURN_DEAD_B: turn_dead_b_reg <= cfg_data;
                REG_TURN_EDGE_B: turn_edge_b_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    jddm_axis_front u_fwd_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (accept),
        .pos       (axis_y),
        .edge_a    (fwd_edge_a_reg),
        .dead_a    (fwd_dead_a_reg),
        .dead_b    (fwd_dead_b_reg),
        .edge_b    (fwd_edge_b_reg),
        .out_valid (fwd_front_valid),
        .job       (fwd_job)
    );

    jddm_axis_front u_turn_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (accept),
        .pos       (turn_pos),
        .edge_a    (turn_edge_a_reg),
        .dead_a    (turn_dead_a_reg),
        .dead_b    (turn_dead_b_reg),
        .edge_b    (turn_edge_b_reg),
        .out_valid (turn_front_valid),
        .job       (turn_job)
    );

    jddm_div u_fwd_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fwd_front_valid),
        .job       (fwd_job),
        .out_valid (fwd_div_valid),
        .res       (fwd_quo)
    );

    jddm_div u_turn_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (turn_front_valid),
        .job       (turn_job),
        .out_valid (turn_div_valid),
        .res       (turn_quo)
    );

    jddm_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fwd_div_valid && turn_div_valid),
        .fwd_quo   (fwd_quo),
        .turn_quo  (turn_quo),
        .out_valid (mix_valid),
        .result    (mix_res)
    );

    assign m_tvalid = mix_valid;
    assign m_tdata  = {mix_res.turn_state, mix_res.right_speed, mix_res.left_speed};

    `JDDM_ASSERT_NOW(a_turn_code, m_tvalid, m_tdata[31:30] <= STEER_RIGHT)
    `JDDM_ASSERT_NOW(a_speed_range, m_tvalid,
        $signed(m_tdata[14:0]) <= LIM15 && $signed(m_tdata[14:0]) >= -LIM15 &&
        $signed(m_tdata[29:15]) <= LIM15 && $signed(m_tdata[29:15]) >= -LIM15)
    `JDDM_ASSERT_NOW(a_straight_equal, m_tvalid && m_tdata[31:30] == STEER_STRAIGHT,
        m_tdata[14:0] == m_tdata[29:15])
    `JDDM_ASSERT_NEXT(a_front_hold, !s_tready,
        $stable(fwd_job) && $stable(turn_job) && $stable(fwd_front_valid))
    `JDDM_ASSERT_NOW(a_lanes_aligned, 1'b1,
        fwd_div_valid == turn_div_valid && fwd_front_valid == turn_front_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import jddm_pkg::*;

    localparam int PIPE_LAT    = NUM_W + 4;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 155;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = '1;

    typedef enum logic {ROW_RPT, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [POS_W-1:0]       val;
        logic [31:0]            rpt;
        logic                   typed;
        logic [SPEED_W-1:0]     exp_l;
        logic [SPEED_W-1:0]     exp_r;
        logic [STATE_W-1:0]     exp_st;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [POS_W-1:0]       cfg_data = '0;

    logic [POS_W-1:0] dz_regs [NUM_REGS];
    logic [POS_W-1:0] reg_defaults [NUM_REGS] = '{1023, 540, 480, 0, 0, 118, 138, 255};

    mix_result_t pending_cmds [$];

    int  fail_count = 0;
    int  n_reports = 0;
    int  n_results = 0;
    int  stuck_cycles = 0;
    int  src_idle_pct = 0;
    int  dst_stall_pct = 0;
    int  hold_left = 0;
    bit  hold_tgl = 1'b0;
    bit  hold_seen = 1'b0;
    bit  traffic = 1'b0;

    stim_row_t directed_rows [24] = '{
        '{ROW_RPT, '0, '0, 32'h0000_0000, 1'b1, 127, 64, STEER_LEFT},
        '{ROW_RPT, '0, '0, 32'hFFFF_FFFF, 1'b1, -127, -64, STEER_RIGHT},
        '{ROW_RPT, '0, '0, 32'h8007_F800, 1'b1, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h55AA_55AA, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'hAA55_AA55, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_FWD_EDGE_A, 600, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_FWD_DEAD_A, 600, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_FWD_DEAD_B, 600, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_FWD_EDGE_B, 599, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_OUT_OF_RANGE, 0, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_FIRST_UNUSED, 1023, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h800F_FC00, 1'b1, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h8004_B000, 1'b1, -127, -127, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h8000_0000, 1'b1, 127, 127, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h8009_6000, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_TURN_EDGE_A, 255, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_TURN_DEAD_A, 140, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_TURN_DEAD_B, 116, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_TURN_EDGE_B, 0, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h0007_F800, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'hFF07_F800, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_CFG, REG_TURN_EDGE_B, 116, '0, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h0007_F800, 1'b0, 0, 0, STEER_STRAIGHT},
        '{ROW_RPT, '0, '0, 32'h8B07_F800, 1'b0, 0, 0, STEER_STRAIGHT}
    };

    joystick_deadzone_drive_mixer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int deadzone_scale(input int pos, input logic [POS_W-1:0] edge_a,
                                          input logic [POS_W-1:0] dead_a,
                                          input logic [POS_W-1:0] dead_b,
                                          input logic [POS_W-1:0] edge_b);
        int ea, za, zb, eb, num, den, quo;
        logic signed [15:0] wrapped;
        bit rising;
        ea = int'(edge_a);
        za = int'(dead_a);
        zb = int'(dead_b);
        eb = int'(edge_b);
        rising = eb > ea;
        if ((rising && pos < za) || (!rising && pos > za)) begin
            num = -SPEED_LIMIT * (pos - za);
            den = ea - za;
        end else if ((rising && pos > zb) || (!rising && pos < zb)) begin
            num = SPEED_LIMIT * (pos - zb);
            den = eb - zb;
        end else begin
            return 0;
        end
        if (den == 0)
            return 0;
        quo = num / den;
        wrapped = quo[15:0];
        return int'(wrapped);
    endfunction

    function automatic int clamp_speed(input int v);
        if (v > SPEED_LIMIT)
            return SPEED_LIMIT;
        if (v < -SPEED_LIMIT)
            return -SPEED_LIMIT;
        return v;
    endfunction

    function automatic mix_result_t drive_mix_predict(input logic [31:0] rpt);
        int ax, ay, az, fwd, turn, left, right;
        mix_result_t res;
        ax = int'(rpt[9:0]);
        ay = int'(rpt[19:10]);
        az = int'(rpt[31:24]);
        fwd = deadzone_scale(ay, dz_regs[REG_FWD_EDGE_A], dz_regs[REG_FWD_DEAD_A],
                             dz_regs[REG_FWD_DEAD_B], dz_regs[REG_FWD_EDGE_B]);
        turn = deadzone_scale(TURN_FROM_TWIST ? az : ax,
                              dz_regs[REG_TURN_EDGE_A], dz_regs[REG_TURN_DEAD_A],
                              dz_regs[REG_TURN_DEAD_B], dz_regs[REG_TURN_EDGE_B]);
        if (fwd > SPEED_LIMIT)
            fwd = SPEED_LIMIT;
        if (turn > SPEED_LIMIT)
            turn = SPEED_LIMIT;
        res.turn_state = (turn < 0) ? STEER_LEFT : (turn > 0) ? STEER_RIGHT : STEER_STRAIGHT;
        left = clamp_speed(fwd - turn / 2);
        right = clamp_speed(fwd + turn / 2);
        res.left_speed = left[SPEED_W-1:0];
        res.right_speed = right[SPEED_W-1:0];
        return res;
    endfunction

    function automatic int jitter(input int v, input int top);
        int t;
        t = v + int'($urandom_range(4)) - 2;
        if (t < 0)
            t = 0;
        if (t > top)
            t = top;
        return t;
    endfunction

    // aim half the axes at the dead-zone and edge positions
    function automatic logic [31:0] random_report();
        logic [POS_W-1:0] x, y;
        logic [7:0] tw;
        logic [3:0] pad;
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        tw = 8'($urandom);
        pad = 4'($urandom);
        if ($urandom_range(1))
            y = POS_W'(jitter(int'(dz_regs[REG_FWD_EDGE_A + $urandom_range(3)]), 1023));
        if ($urandom_range(1)) begin
            x = POS_W'(jitter(int'(dz_regs[REG_TURN_EDGE_A + $urandom_range(3)]), 1023));
            tw = 8'(jitter(int'(dz_regs[REG_TURN_EDGE_A + $urandom_range(3)]), 255));
        end
        return {tw, pad, y, x};
    endfunction

    task automatic settle();
        if (!traffic)
            return;
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
        repeat (PIPE_LAT) @(negedge aclk);
        traffic = 1'b0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS)
            dz_regs[idx] = val;
        @(negedge aclk);
    endtask

    task automatic send_report(input logic [31:0] rpt, input logic typed,
                               input mix_result_t known);
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rpt;
        traffic = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_cmds.push_back(typed ? known : drive_mix_predict(rpt));
        n_reports++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen = hold_tgl;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        mix_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_cmds.size() == 0) begin
                $error("result with no report pending: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                n_results++;
                if (got.left_speed !== want.left_speed) begin
                    $error("left_speed: expected %0d, got %0d",
                           $signed(want.left_speed), $signed(got.left_speed));
                    fail_count++;
                end
                if (got.right_speed !== want.right_speed) begin
                    $error("right_speed: expected %0d, got %0d",
                           $signed(want.right_speed), $signed(got.right_speed));
                    fail_count++;
                end
                if (got.turn_state !== want.turn_state) begin
                    $error("turn_state: expected %0d, got %0d",
                           want.turn_state, got.turn_state);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [POS_W-1:0] plan [NUM_REGS];
        mix_result_t known;
        foreach (dz_regs[r])
            dz_regs[r] = reg_defaults[r];
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                apply_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                known.left_speed = directed_rows[i].exp_l;
                known.right_speed = directed_rows[i].exp_r;
                known.turn_state = directed_rows[i].exp_st;
                send_report(directed_rows[i].rpt, directed_rows[i].typed, known);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            foreach (plan[r])
                plan[r] = POS_W'($urandom);
            case (p)
                0: plan = reg_defaults;
                1: plan = '{0, 0, 0, 0, 0, 0, 0, 0};
                2: plan = '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023};
                3: plan = '{0, 500, 520, 1023, 255, 140, 116, 0};
                6: begin
                    // forward divisor of minus one, so the scaled value wraps
                    plan[REG_FWD_EDGE_A] = 1023;
                    plan[REG_FWD_DEAD_A] = 1000;
                    plan[REG_FWD_DEAD_B] = 520;
                    plan[REG_FWD_EDGE_B] = 519;
                end
                7: plan = '{300, 300, 700, 700, 50, 50, 200, 200};
                default: ;
            endcase
            foreach (plan[r])
                apply_reg(CFG_IDX_W'(r), plan[r]);
            apply_reg(REG_OUT_OF_RANGE, POS_W'($urandom));

            case (p % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct <= 0;  end
                1: begin src_idle_pct = 85; dst_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct <= 85; end
                default: begin src_idle_pct = 11; dst_stall_pct <= 11; end
            endcase

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 60)
                    hold_tgl <= ~hold_tgl;
                if (p == 1 && k == 80)
                    settle();
                send_report(random_report(), 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        $display("Covered %0d reports (%0d random over %0d register settings), %0d checked",
                 n_reports, PHASES * PHASE_ITEMS, PHASES, n_results);
        $display("Idle mixes: none, sender 85%%, receiver 85%%, both 11%%; "
                 , "one long receiver hold-off and one full drain mid-stream");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
